/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files, included by pch_back
// uses the clk and rst names of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PCH_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden state");
`else
`define PCH_ASSERT(lbl, prop)
`define PCH_NEVER(lbl, expr)
`endif
`endif

/* hw/rtl/pch_pkg.sv */
// shared types and constants of the pulse calibration histogrammer
// no dependencies
package pch_pkg;
  localparam int NUM_BINS = 50;
  localparam int TABLE_DEPTH = 64;
  localparam int HIST_AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DIV_W = 53;
  // top scale is bottom * 4096 / ratio and can reach 36 bits
  localparam int DSR_W = 36;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [2:0] REG_TARGET_RUN = 3'd0;
  localparam logic [2:0] REG_SPE_MODE = 3'd1;
  localparam logic [2:0] REG_FIT_INTERCEPT = 3'd2;
  localparam logic [2:0] REG_FIT_SLOPE = 3'd3;
  localparam logic [2:0] REG_FIXED_SPE = 3'd4;
  localparam logic [2:0] REG_TOP_RATIO = 3'd5;
  localparam logic [2:0] REG_HIST_LOW = 3'd6;
  localparam logic [2:0] REG_BIN_WIDTH = 3'd7;

  localparam logic [1:0] FUNC_EVENT = 2'd0;
  localparam logic [1:0] FUNC_TWRITE = 2'd1;
  localparam logic [1:0] FUNC_BREAD = 2'd2;

  localparam logic [1:0] MODE_FIT = 2'd0;
  localparam logic [1:0] MODE_TABLE = 2'd2;

  localparam logic [2:0] K_NOP = 3'd0;
  localparam logic [2:0] K_REJ = 3'd1;
  localparam logic [2:0] K_ACC = 3'd2;
  localparam logic [2:0] K_TWR = 3'd3;
  localparam logic [2:0] K_BRD = 3'd4;

  typedef struct packed {
    logic [15:0] target_run;
    logic [1:0] spe_mode;
    logic [23:0] fit_intercept;
    logic signed [23:0] fit_slope;
    logic [23:0] fixed_spe;
    logic [15:0] top_ratio;
    logic [15:0] hist_low;
    logic [7:0] bin_width;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] ts;
    logic signed [31:0] it;
    logic signed [31:0] ib;
    logic [5:0] eidx;
    logic [31:0] etime;
    logic [23:0] etop;
    logic [23:0] ebot;
    logic [5:0] bsel;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic signed [39:0] calibrated_pe;
    logic in_histogram;
    logic [5:0] bin_index;
    logic [31:0] bin_count;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic scale_zero;
  } res_t;
endpackage

/* hw/rtl/pch_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on pch_pkg
module pch_div import pch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic busy,
  output logic done,
  output logic [DIV_W-1:0] quotient
);
  logic [DCNT_W-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DIV_W-1:0] dq;
  logic [DSR_W:0] trial;
  logic ge;

  assign trial = {rem, dq[DIV_W-1]};
  assign ge = trial >= {1'b0, dsr};
  assign busy = cnt != '0;
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dq <= dividend;
    end else if (busy) begin
      rem <= ge ? DSR_W'(trial - {1'b0, dsr}) : DSR_W'(trial);
      dq <= {dq[DIV_W-2:0], ge};
    end
  end
endmodule

/* hw/rtl/pch_front.sv */
// front end: classifies items and holds them in a two-entry queue
// depends on pch_pkg
module pch_front import pch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic push,
  output logic full,
  input  logic [1:0] func,
  input  logic [15:0] run_number,
  input  logic signed [31:0] integral_top,
  input  logic signed [31:0] integral_bottom,
  input  logic signed [31:0] baseline_top,
  input  logic signed [31:0] baseline_bottom,
  input  logic [31:0] timestamp,
  input  logic [5:0] entry_index,
  input  logic [31:0] entry_time,
  input  logic [23:0] entry_spe_top,
  input  logic [23:0] entry_spe_bottom,
  input  logic [5:0] bin_select,
  output logic q_valid,
  input  logic q_pop,
  output cmd_t q_data
);
  cmd_t slots [2];
  logic [1:0] cnt;
  logic wptr, rptr;
  cmd_t cmd_in;
  logic good;
  logic wr;

  assign good = run_number == cfg.target_run && integral_top != 0 &&
                integral_bottom != 0 && baseline_top != 0 && baseline_bottom != 0;

  always_comb begin
    cmd_in.ts = timestamp;
    cmd_in.it = integral_top;
    cmd_in.ib = integral_bottom;
    cmd_in.eidx = entry_index;
    cmd_in.etime = entry_time;
    cmd_in.etop = entry_spe_top;
    cmd_in.ebot = entry_spe_bottom;
    cmd_in.bsel = bin_select;
    case (func)
      FUNC_EVENT: cmd_in.kind = good ? K_ACC : K_REJ;
      FUNC_TWRITE: cmd_in.kind = K_TWR;
      FUNC_BREAD: cmd_in.kind = K_BRD;
      default: cmd_in.kind = K_NOP;
    endcase
  end

  assign full = cnt == 2'd2;
  assign wr = push && !full;
  assign q_valid = cnt != 2'd0;
  assign q_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (wr) wptr <= !wptr;
      if (q_pop) rptr <= !rptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= cmd_in;
  end
endmodule

/* hw/rtl/pch_back.sv */
// back end: scale lookup, pe conversion, histogram and time tracking
// depends on pch_pkg, pch_div and assert_macros.svh
`include "assert_macros.svh"
module pch_back import pch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_data,
  output logic res_valid,
  input  logic res_pop,
  output res_t res
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FMUL = 4'd1;
  localparam logic [3:0] S_FADD = 4'd2;
  localparam logic [3:0] S_BCHK = 4'd3;
  localparam logic [3:0] S_TDIV = 4'd4;
  localparam logic [3:0] S_TRD = 4'd5;
  localparam logic [3:0] S_TCMP = 4'd6;
  localparam logic [3:0] S_PDIV1 = 4'd7;
  localparam logic [3:0] S_PDIV2 = 4'd8;
  localparam logic [3:0] S_BIN = 4'd9;
  localparam logic [3:0] S_BDIV = 4'd10;
  localparam logic [3:0] S_HRD = 4'd11;
  localparam logic [3:0] S_HUPD = 4'd12;
  localparam logic [3:0] S_OUT = 4'd13;

  localparam logic signed [54:0] PE_MAX = 55'sd549755813887;
  localparam logic signed [54:0] PE_MIN = -55'sd549755813888;

  logic [3:0] state;
  cmd_t cmd;
  logic signed [30:0] scale_b;
  logic [23:0] bot_s;
  logic signed [56:0] prod;
  logic signed [53:0] q1;
  logic signed [39:0] pe;
  logic acc, szero, inh;
  logic [5:0] bidx;
  logic [31:0] bcnt;
  logic [31:0] earliest, latest;
  logic early_valid;
  logic [TAB_AW-1:0] k;
  logic [HIST_AW-1:0] haddr;

  logic div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [DSR_W-1:0] div_dsr;

  logic [31:0] tab_time [TABLE_DEPTH];
  logic [23:0] tab_top [TABLE_DEPTH];
  logic [23:0] tab_bot [TABLE_DEPTH];
  logic [31:0] tq_time;
  logic [23:0] tq_top, tq_bot;

  logic [31:0] hist [NUM_BINS];
  logic [NUM_BINS-1:0] hvalid;
  logic [31:0] hq;

  logic signed [30:0] fit_sum;
  logic signed [54:0] pe_sum;
  logic signed [40:0] pe_off;
  logic [31:0] cur_cnt, new_cnt;
  logic [31:0] mag_it, mag_ib;
  logic signed [53:0] q_signed;
  logic tab_wr, hist_wr;

  pch_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign q_pop = state == S_IDLE && q_valid;
  // arithmetic shift of the slope product, rounds toward minus infinity
  assign fit_sum = $signed({7'd0, cfg.fit_intercept}) + 31'($signed(prod[56:28]));
  assign mag_it = cmd.it[31] ? 32'(-cmd.it) : cmd.it;
  assign mag_ib = cmd.ib[31] ? 32'(-cmd.ib) : cmd.ib;
  assign q_signed = $signed({1'b0, div_q});
  assign pe_sum = 55'(q1) + 55'(cmd.ib[31] ? -q_signed : q_signed);
  assign pe_off = 41'(pe) - $signed({17'd0, cfg.hist_low, 8'd0});
  assign cur_cnt = hvalid[haddr] ? hq : 32'd0;
  assign new_cnt = (cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1;
  assign tab_wr = q_pop && q_data.kind == K_TWR &&
                  {1'b0, q_data.eidx} < 7'(TABLE_DEPTH);
  assign hist_wr = state == S_HUPD && cmd.kind == K_ACC;

  // step table, read port registered
  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_time[q_data.eidx[TAB_AW-1:0]] <= q_data.etime;
      tab_top[q_data.eidx[TAB_AW-1:0]] <= q_data.etop;
      tab_bot[q_data.eidx[TAB_AW-1:0]] <= q_data.ebot;
    end
    tq_time <= tab_time[k];
    tq_top <= tab_top[k];
    tq_bot <= tab_bot[k];
  end

  // histogram bins, valid bits stand in for the cleared state
  always_ff @(posedge clk) begin
    if (hist_wr) hist[haddr] <= new_cnt;
    hq <= hist[haddr];
  end

  always_ff @(posedge clk) begin
    if (rst) hvalid <= '0;
    else if (hist_wr) hvalid[haddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      earliest <= '0;
      latest <= '0;
      early_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_pop && res_valid) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_data;
            acc <= 1'b0;
            szero <= 1'b0;
            inh <= 1'b0;
            bidx <= '0;
            bcnt <= '0;
            pe <= '0;
            k <= '0;
            state <= S_OUT;
            if (q_data.kind == K_ACC) begin
              acc <= 1'b1;
              if (!early_valid || q_data.ts <= earliest) begin
                earliest <= q_data.ts;
                early_valid <= 1'b1;
              end
              if (q_data.ts >= latest) latest <= q_data.ts;
              if (cfg.spe_mode == MODE_FIT) begin
                state <= S_FMUL;
              end else if (cfg.spe_mode == MODE_TABLE) begin
                state <= S_TRD;
              end else begin
                scale_b <= $signed({7'd0, cfg.fixed_spe});
                state <= S_BCHK;
              end
            end else if (q_data.kind == K_BRD) begin
              bidx <= q_data.bsel;
              if (7'(q_data.bsel) < 7'(NUM_BINS)) begin
                haddr <= q_data.bsel[HIST_AW-1:0];
                state <= S_HRD;
              end
            end
          end
        end
        S_FMUL: begin
          prod <= cfg.fit_slope * $signed({1'b0, cmd.ts});
          state <= S_FADD;
        end
        S_FADD: begin
          scale_b <= (fit_sum > 31'sh0FF_FFFF) ? 31'sh0FF_FFFF : fit_sum;
          state <= S_BCHK;
        end
        S_BCHK: begin
          bot_s <= scale_b[23:0];
          if (scale_b <= 0 || cfg.top_ratio == '0) begin
            szero <= 1'b1;
            state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            div_dvd <= DIV_W'({scale_b[23:0], 12'd0});
            div_dsr <= DSR_W'(cfg.top_ratio);
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            if (div_q == '0) begin
              szero <= 1'b1;
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              div_dvd <= {1'b0, mag_it, 20'd0};
              div_dsr <= div_q[DSR_W-1:0];
              state <= S_PDIV1;
            end
          end
        end
        S_TRD: state <= S_TCMP;
        S_TCMP: begin
          if (k != TAB_AW'(TABLE_DEPTH - 1) && cmd.ts >= tq_time) begin
            k <= k + 1'b1;
            state <= S_TRD;
          end else begin
            bot_s <= tq_bot;
            if (tq_top == '0 || tq_bot == '0) begin
              szero <= 1'b1;
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              div_dvd <= {1'b0, mag_it, 20'd0};
              div_dsr <= DSR_W'(tq_top);
              state <= S_PDIV1;
            end
          end
        end
        S_PDIV1: begin
          if (div_done) begin
            q1 <= cmd.it[31] ? -q_signed : q_signed;
            div_start <= 1'b1;
            div_dvd <= {1'b0, mag_ib, 20'd0};
            div_dsr <= DSR_W'(bot_s);
            state <= S_PDIV2;
          end
        end
        S_PDIV2: begin
          if (div_done) begin
            if (pe_sum > PE_MAX) pe <= PE_MAX[39:0];
            else if (pe_sum < PE_MIN) pe <= PE_MIN[39:0];
            else pe <= pe_sum[39:0];
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (pe_off < 0) begin
            state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            div_dvd <= DIV_W'(pe_off[39:8]);
            div_dsr <= (cfg.bin_width == '0) ? DSR_W'(1) : DSR_W'(cfg.bin_width);
            state <= S_BDIV;
          end
        end
        S_BDIV: begin
          if (div_done) begin
            if (div_q < DIV_W'(NUM_BINS)) begin
              haddr <= div_q[HIST_AW-1:0];
              bidx <= 6'(div_q);
              state <= S_HRD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_HRD: state <= S_HUPD;
        S_HUPD: begin
          if (cmd.kind == K_ACC) begin
            inh <= 1'b1;
            bcnt <= new_cnt;
          end else begin
            bcnt <= cur_cnt;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid) begin
            res.accepted <= acc;
            res.calibrated_pe <= inh || cmd.kind == K_ACC ? pe : '0;
            res.in_histogram <= inh;
            res.bin_index <= (cmd.kind == K_ACC && !inh) ? 6'd0 : bidx;
            res.bin_count <= (cmd.kind == K_ACC && !inh) ? 32'd0 : bcnt;
            res.first_time <= earliest;
            res.last_time <= latest;
            res.scale_zero <= szero;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PCH_NEVER(a_div_overlap, div_start && div_busy)
  `PCH_ASSERT(a_hist_implies_acc, res_valid && res.in_histogram |-> res.accepted && !res.scale_zero)
  `PCH_ASSERT(a_time_order, early_valid |-> earliest <= latest)
endmodule

/* hw/rtl/pulse_calibration_histogrammer.sv */
// top level of the pulse calibration histogrammer
// depends on pch_pkg, pch_front, pch_back
//
// channel  | handshake            | carries
// ---------+----------------------+----------------------------------------
// input    | push / full          | func, event fields, table entry, bin
// result   | empty / pop          | accepted, pe, bin, count, times, flags
// config   | cfg_valid / ready    | cfg_index, cfg_data (24 bit)
//
// an item is taken into a two-entry queue; the back end then works one item at
// a time. a fit-mode event runs a multiply, an add and up to four divisions on
// the shared one-bit-per-cycle divider; fixed mode skips the multiply and add,
// table mode drops the scale division and instead reads and compares table
// entries in turn. table writes and rejected events go straight to the result
// step, bin reads first read the bin. reset is synchronous; the histogram is
// cleared at once through per-bin valid bits, no clearing pass. a result waiting
// on pop stalls the back end, while the queue keeps taking items until it is full
module pulse_calibration_histogrammer import pch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] func,
  input  logic [15:0] run_number,
  input  logic signed [31:0] integral_top,
  input  logic signed [31:0] integral_bottom,
  input  logic signed [31:0] baseline_top,
  input  logic signed [31:0] baseline_bottom,
  input  logic [31:0] timestamp,
  input  logic [5:0] entry_index,
  input  logic [31:0] entry_time,
  input  logic [23:0] entry_spe_top,
  input  logic [23:0] entry_spe_bottom,
  input  logic [5:0] bin_select,
  output logic empty,
  input  logic pop,
  output logic accepted,
  output logic signed [39:0] calibrated_pe,
  output logic in_histogram,
  output logic [5:0] bin_index,
  output logic [31:0] bin_count,
  output logic [31:0] first_time,
  output logic [31:0] last_time,
  output logic scale_zero,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data
);
  cfg_t cfg;
  logic q_valid, q_pop;
  cmd_t q_data;
  logic res_valid;
  res_t res;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_run <= 16'd0;
      cfg.spe_mode <= 2'd1;
      cfg.fit_intercept <= 24'd730849;
      cfg.fit_slope <= -24'sd79165;
      cfg.fixed_spe <= 24'd262144;
      cfg.top_ratio <= 16'd4833;
      cfg.hist_low <= 16'd400;
      cfg.bin_width <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_RUN: cfg.target_run <= cfg_data[15:0];
        REG_SPE_MODE: cfg.spe_mode <= cfg_data[1:0];
        REG_FIT_INTERCEPT: cfg.fit_intercept <= cfg_data;
        REG_FIT_SLOPE: cfg.fit_slope <= $signed(cfg_data);
        REG_FIXED_SPE: cfg.fixed_spe <= cfg_data;
        REG_TOP_RATIO: cfg.top_ratio <= cfg_data[15:0];
        REG_HIST_LOW: cfg.hist_low <= cfg_data[15:0];
        REG_BIN_WIDTH: cfg.bin_width <= cfg_data[7:0];
        default: cfg.bin_width <= cfg.bin_width;
      endcase
    end
  end

  // front end: classify and queue
  pch_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .full(full), .func(func),
    .run_number(run_number), .integral_top(integral_top),
    .integral_bottom(integral_bottom), .baseline_top(baseline_top),
    .baseline_bottom(baseline_bottom), .timestamp(timestamp),
    .entry_index(entry_index), .entry_time(entry_time),
    .entry_spe_top(entry_spe_top), .entry_spe_bottom(entry_spe_bottom),
    .bin_select(bin_select), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  // back end: calibration, histogram, result register
  pch_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .res_valid(res_valid), .res_pop(pop), .res(res)
  );

  assign empty = !res_valid;
  assign accepted = res.accepted;
  assign calibrated_pe = res.calibrated_pe;
  assign in_histogram = res.in_histogram;
  assign bin_index = res.bin_index;
  assign bin_count = res.bin_count;
  assign first_time = res.first_time;
  assign last_time = res.last_time;
  assign scale_zero = res.scale_zero;
endmodule

/* tb/pulse_calibration_histogrammer_tb.sv */
// testbench of the pulse calibration histogrammer: random and directed items
// checked against an in-bench predictor of the pe calibration and histogram
// depends on pch_pkg and pulse_calibration_histogrammer
`timescale 1ns / 100ps

module pulse_calibration_histogrammer_tb;
  import pch_pkg::*;

  typedef struct {
    logic [1:0] fn;
    logic [15:0] run;
    logic signed [31:0] it, ib, bt, bb;
    logic [31:0] ts;
    logic [5:0] eidx;
    logic [31:0] etime;
    logic [23:0] etop, ebot;
    logic [5:0] bsel;
  } item_t;

  logic clk, rst;
  logic push, full, empty, pop;
  logic [1:0] func;
  logic [15:0] run_number;
  logic signed [31:0] integral_top, integral_bottom, baseline_top, baseline_bottom;
  logic [31:0] timestamp, entry_time;
  logic [5:0] entry_index, bin_select;
  logic [23:0] entry_spe_top, entry_spe_bottom;
  logic accepted, in_histogram, scale_zero;
  logic signed [39:0] calibrated_pe;
  logic [5:0] bin_index;
  logic [31:0] bin_count, first_time, last_time;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  pulse_calibration_histogrammer dut (.*);

  // predictor state
  cfg_t cfg;
  logic [31:0] hist_counts [NUM_BINS];
  logic [31:0] tab_time [TABLE_DEPTH];
  logic [23:0] tab_top [TABLE_DEPTH];
  logic [23:0] tab_bot [TABLE_DEPTH];
  logic [31:0] t_first, t_last;
  bit first_seen;

  item_t pending_items[$];
  res_t expected_results[$];
  int errors = 0;
  int n_events = 0, n_binned = 0, n_results = 0;
  bit hold_pop = 0;       // long receiver hold-off
  bit quiet = 0;          // stretch with no idling

  // expected outcome of one item, updates predictor state
  function automatic res_t calibrate(item_t x);
    res_t r;
    longint b, top, bot, pe, d, w, p;
    int k;
    bit ok;
    r = '0;
    if (x.fn == FUNC_EVENT) begin
      if (x.run == cfg.target_run && x.it != 0 && x.ib != 0 && x.bt != 0 && x.bb != 0) begin
        r.accepted = 1;
        n_events++;
        if (!first_seen || x.ts <= t_first) begin
          t_first = x.ts;
          first_seen = 1;
        end
        if (x.ts >= t_last) t_last = x.ts;
        ok = 1;
        if (cfg.spe_mode == MODE_TABLE) begin
          k = 0;
          while (k < TABLE_DEPTH - 1 && x.ts >= tab_time[k]) k++;
          top = tab_top[k];
          bot = tab_bot[k];
          ok = (top != 0 && bot != 0);
        end else begin
          if (cfg.spe_mode == MODE_FIT) begin
            p = longint'(cfg.fit_slope) * longint'({32'd0, x.ts});
            b = longint'({40'd0, cfg.fit_intercept}) + (p >>> 28);  // arithmetic = floor
            if (b > 64'sh0FF_FFFF) b = 64'sh0FF_FFFF;
          end else b = cfg.fixed_spe;
          if (b <= 0 || cfg.top_ratio == 0) ok = 0;
          else begin
            bot = b;
            top = (b << 12) / longint'({48'd0, cfg.top_ratio});
            ok = (top != 0);
          end
        end
        if (!ok) r.scale_zero = 1;
        else begin
          pe = (longint'(x.it) * 1048576) / top + (longint'(x.ib) * 1048576) / bot;
          if (pe > 64'sd549755813887) pe = 64'sd549755813887;
          if (pe < -64'sd549755813888) pe = -64'sd549755813888;
          r.calibrated_pe = pe[39:0];
          d = pe - longint'(cfg.hist_low) * 256;
          w = (cfg.bin_width == 0 ? 1 : longint'(cfg.bin_width)) * 256;
          if (d >= 0 && d / w < NUM_BINS) begin
            k = int'(d / w);
            if (hist_counts[k] != 32'hFFFFFFFF) hist_counts[k]++;
            r.in_histogram = 1;
            r.bin_index = 6'(k);
            r.bin_count = hist_counts[k];
            n_binned++;
          end
        end
      end
    end else if (x.fn == FUNC_TWRITE) begin
      tab_time[x.eidx] = x.etime;
      tab_top[x.eidx] = x.etop;
      tab_bot[x.eidx] = x.ebot;
    end else if (x.fn == FUNC_BREAD) begin
      r.bin_index = x.bsel;
      r.bin_count = (x.bsel < NUM_BINS) ? hist_counts[x.bsel] : 32'd0;
    end
    r.first_time = t_first;
    r.last_time = t_last;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // driver: offers the oldest pending item, idles at random
  always @(posedge clk) begin
    item_t x;
    if (rst) push <= 0;
    else begin
      if (push && !full) begin
        x = pending_items.pop_front();
        expected_results = {expected_results, calibrate(x)};
      end
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
        x = pending_items[0];
        push <= 1;
        func <= x.fn; run_number <= x.run;
        integral_top <= x.it; integral_bottom <= x.ib;
        baseline_top <= x.bt; baseline_bottom <= x.bb;
        timestamp <= x.ts; entry_index <= x.eidx; entry_time <= x.etime;
        entry_spe_top <= x.etop; entry_spe_bottom <= x.ebot; bin_select <= x.bsel;
      end else push <= 0;
    end
  end

  // monitor: compares each popped item with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst) pop <= 0;
    else begin
      if (pop && !empty) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item", $time);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if ({accepted, calibrated_pe, in_histogram, bin_index, bin_count,
               first_time, last_time, scale_zero} !== e) begin
            errors++;
            $display("%0t: mismatch exp acc=%0d pe=%0d inh=%0d bin=%0d cnt=%0d ft=%0d lt=%0d sz=%0d",
                     $time, e.accepted, e.calibrated_pe, e.in_histogram, e.bin_index,
                     e.bin_count, e.first_time, e.last_time, e.scale_zero);
            $display("%0t:          got acc=%0d pe=%0d inh=%0d bin=%0d cnt=%0d ft=%0d lt=%0d sz=%0d",
                     $time, accepted, calibrated_pe, in_histogram, bin_index,
                     bin_count, first_time, last_time, scale_zero);
          end
        end
      end
      pop <= !hold_pop && (quiet || $urandom_range(99) >= 21);
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || push || expected_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_TARGET_RUN:    cfg.target_run = val[15:0];
      REG_SPE_MODE:      cfg.spe_mode = val[1:0];
      REG_FIT_INTERCEPT: cfg.fit_intercept = val;
      REG_FIT_SLOPE:     cfg.fit_slope = val;
      REG_FIXED_SPE:     cfg.fixed_spe = val;
      REG_TOP_RATIO:     cfg.top_ratio = val[15:0];
      REG_HIST_LOW:      cfg.hist_low = val[15:0];
      default:           cfg.bin_width = val[7:0];
    endcase
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // event, mostly of the target run; mostly sized to land in the histogram
  function automatic item_t make_event(bit noisy);
    item_t x;
    x = '{default: 0};
    x.fn = FUNC_EVENT;
    x.run = ($urandom_range(9) == 0) ? 16'($urandom) : cfg.target_run;
    x.ts = ($urandom_range(3) == 0) ? rnd32() : 32'($urandom_range(5000));
    if (noisy) begin
      x.it = rnd32(); x.ib = rnd32();
    end else begin
      x.it = $signed(32'($urandom_range(200000))) - 32'sd20000;
      x.ib = $signed(32'($urandom_range(200000))) - 32'sd20000;
    end
    x.bt = ($urandom_range(15) == 0) ? 0 : rnd32() | 1;
    x.bb = ($urandom_range(15) == 0) ? 0 : rnd32() | 2;
    if ($urandom_range(19) == 0) x.it = 0;
    if ($urandom_range(19) == 0) x.ib = 0;
    return x;
  endfunction

  function automatic item_t other_item();
    item_t x;
    x = '{default: 0};
    x.fn = 2'($urandom_range(3));
    if (x.fn == FUNC_TWRITE) x.fn = 2'd3;  // table kept fixed during random phases
    x.bsel = 6'($urandom);
    x.eidx = 6'($urandom); x.etime = rnd32(); x.etop = 24'($urandom); x.ebot = 24'($urandom);
    x.run = 16'($urandom); x.ts = rnd32();
    return x;
  endfunction

  initial begin
    item_t x;
    int m;
    rst = 1;
    push = 0; pop = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    func = 0; run_number = 0; integral_top = 0; integral_bottom = 0;
    baseline_top = 0; baseline_bottom = 0; timestamp = 0; entry_index = 0;
    entry_time = 0; entry_spe_top = 0; entry_spe_bottom = 0; bin_select = 0;
    cfg = '{target_run: 0, spe_mode: 1, fit_intercept: 730849, fit_slope: -79165,
            fixed_spe: 262144, top_ratio: 4833, hist_low: 400, bin_width: 10};
    foreach (hist_counts[i]) hist_counts[i] = 0;
    t_first = 0; t_last = 0; first_seen = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fill the whole table, ascending times, extremes of the scales
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      x = '{default: 0};
      x.fn = FUNC_TWRITE; x.eidx = 6'(i);
      x.etime = (i == TABLE_DEPTH - 1) ? 32'hFFFFFFFF : 32'(i * 1000);
      x.etop = (i == 0) ? 24'hFFFFFF : (i == 1) ? 24'd1 : 24'(200000 + i * 3000);
      x.ebot = (i == 0) ? 24'd1 : (i == 1) ? 24'hFFFFFF : 24'(300000 + i * 2000);
      pending_items = {pending_items, x};
    end
    // directed events at reset config: extremes, rejects, bin reads
    x = '{default: 0}; x.fn = FUNC_EVENT;
    x.it = 32'sh7FFFFFFF; x.ib = 32'sh7FFFFFFF; x.bt = -1; x.bb = 32'sh80000000;
    x.ts = 32'hFFFFFFFF; pending_items = {pending_items, x};
    x.it = 32'sh80000000; x.ib = 32'sh80000000; x.ts = 0; pending_items = {pending_items, x};
    x.it = 12000; x.ib = 12000; x.ts = 77; pending_items = {pending_items, x};
    x.bt = 0; pending_items = {pending_items, x};                 // bad baseline
    x.bt = 5; x.run = 16'hFFFF; pending_items = {pending_items, x}; // wrong run
    x = '{default: 0}; x.fn = FUNC_BREAD; x.bsel = 63; pending_items = {pending_items, x};
    x.bsel = 0; pending_items = {pending_items, x};
    x.fn = 2'd3; pending_items = {pending_items, x};               // unused function
    wait_drained();

    // settings sweep, each with a random phase; last phase stresses backpressure
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SPE_MODE, MODE_FIT);
          write_reg(REG_TARGET_RUN, 16'hFFFF);
          write_reg(REG_FIT_INTERCEPT, 730849);
          write_reg(REG_FIT_SLOPE, -79165);
        end
        1: begin
          write_reg(REG_FIT_INTERCEPT, 24'hFFFFFF);
          write_reg(REG_FIT_SLOPE, 24'h7FFFFF);
          write_reg(REG_TOP_RATIO, 16'hFFFF);
          write_reg(REG_HIST_LOW, 0);
          write_reg(REG_BIN_WIDTH, 255);
        end
        2: begin
          write_reg(REG_FIT_INTERCEPT, 0);
          write_reg(REG_FIT_SLOPE, 24'h800000);             // negative scale
          write_reg(REG_TARGET_RUN, 0);
          write_reg(REG_BIN_WIDTH, 1);
        end
        3: begin
          write_reg(REG_SPE_MODE, MODE_TABLE);
          write_reg(REG_HIST_LOW, 16'hFFFF);
          write_reg(REG_BIN_WIDTH, 0);
        end
        4: begin
          write_reg(REG_SPE_MODE, 2'd3);
          write_reg(REG_FIXED_SPE, 1);
          write_reg(REG_TOP_RATIO, 0);
          write_reg(REG_HIST_LOW, 0);
        end
        default: begin
          write_reg(REG_SPE_MODE, 2'd1);
          write_reg(REG_FIXED_SPE, 24'hFFFFFF);
          write_reg(REG_TOP_RATIO, 1);
          write_reg(REG_BIN_WIDTH, 2);
        end
      endcase
      quiet = (ph == 2);
      if (ph == 5) hold_pop = 1;
      for (int n = 0; n < 70; n++) begin
        m = $urandom_range(9);
        if (m < 7) pending_items = {pending_items, make_event(m == 0)};
        else pending_items = {pending_items, other_item()};
      end
      if (ph == 5) begin
        // receiver holds off while the sender keeps offering
        repeat (3000) @(posedge clk);
        hold_pop = 0;
      end
      wait_drained();
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      x = '{default: 0}; x.fn = FUNC_BREAD; x.bsel = 6'(i);
      pending_items = {pending_items, x};
    end
    wait_drained();

    $display("covered %0d results, %0d accepted events, %0d binned, six settings",
             n_results, n_events, n_binned);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pch_pkg.sv
hw/rtl/pch_div.sv
hw/rtl/pch_front.sv
hw/rtl/pch_back.sv
hw/rtl/pulse_calibration_histogrammer.sv
tb/pulse_calibration_histogrammer_tb.sv
